[hw/rtl/ising_metropolis_site_update_core_macros.svh]
// Concurrent assertion shorthands, clocked on clk and quiet while arst_n is low.
`ifndef ISING_METROPOLIS_SITE_UPDATE_CORE_MACROS_SVH
`define ISING_METROPOLIS_SITE_UPDATE_CORE_MACROS_SVH

// Same-cycle implication.
`define ISMS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ISMS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/isms_pkg.sv]
package isms_pkg;

	localparam int SITE_W    = 12;
	localparam int RND_W     = 16;
	localparam int ENERGY_W  = 15;
	localparam int MAGNET_W  = 14;
	localparam int DE_W      = 5;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;
	localparam int NBR_CNT   = 5;
	localparam int NBR_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_THRESHOLD_DE4 = 1'b0,
		CFG_THRESHOLD_DE8 = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		CMD_TRIAL = 1'b0,
		CMD_FORCE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_EXEC
	} back_state_t;

	typedef struct packed {
		logic             force_wr;
		logic             in_range;
		logic             write_spin;
		logic [RND_W-1:0] random_value;
	} item_ctl_t;

	typedef struct packed {
		logic q_full;
		logic clearing;
	} front_hold_t;

endpackage

[hw/rtl/isms_ram.sv]
module isms_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hw/rtl/isms_fifo.sv]
module isms_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int PW = $clog2(DEPTH),
	localparam int CNTW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             valid,
	output logic             full
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CNTW-1:0]  cnt_q;

	assign dout  = mem_q[rd_ptr_q];
	assign valid = (cnt_q != '0);
	assign full  = (cnt_q == CNTW'(DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

[hw/rtl/isms_front.sv]
module isms_front #(
	parameter int SIDE = 64,
	localparam int SITES = SIDE * SIDE,
	localparam int AW = $clog2(SITES)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              cmd,
	input  logic [isms_pkg::SITE_W-1:0]       site_index,
	input  logic [isms_pkg::RND_W-1:0]        random_value,
	input  logic                              write_spin,
	input  isms_pkg::front_hold_t             hold,
	output logic                              busy,
	output logic                              push,
	output isms_pkg::item_ctl_t               push_ctl,
	output logic [isms_pkg::NBR_CNT-1:0][AW-1:0] push_addr
);

	localparam int SW = isms_pkg::SITE_W;
	localparam int CW = $clog2(SIDE);
	localparam int SHIFT = SW + CW;
	localparam int MW = SW + 2;
	localparam int PW = SW + MW;
	localparam int RW = SW + CW + 1;
	localparam int XW = ((AW > SW) ? AW : SW) + 2;
	localparam longint RECIP_L = ((longint'(1) << SHIFT) + longint'(SIDE) - 1) / longint'(SIDE);

	logic                          v_s1_q;
	logic                          cmd_s1;
	logic [SW-1:0]                 site_s1;
	logic [isms_pkg::RND_W-1:0]    rnd_s1;
	logic                          wsp_s1;
	logic [SW-1:0]                 row_s1;

	logic                          v_s2_q;
	logic                          cmd_s2;
	logic [SW-1:0]                 site_s2;
	logic [isms_pkg::RND_W-1:0]    rnd_s2;
	logic                          wsp_s2;
	logic [CW-1:0]                 col_s2;

	logic [PW-1:0] prod1;
	logic [SW-1:0] row_est;
	logic [RW-1:0] row_base;
	logic [SW-1:0] diff;
	logic [SW-1:0] col_fix;
	logic [XW-1:0] site_x;
	logic          in_range;
	logic          accept;

	assign busy   = hold.clearing | hold.q_full | v_s1_q | v_s2_q;
	assign accept = start & ~busy;

	always_comb begin
		prod1   = PW'(site_index) * PW'(RECIP_L);
		row_est = SW'(prod1 >> SHIFT);
	end

	always_comb begin
		row_base = RW'(row_s1) * RW'(SIDE);
		diff     = site_s1 - SW'(row_base);
		col_fix  = (diff >= SW'(SIDE)) ? diff - SW'(SIDE) : diff;
	end

	always_comb begin
		site_x   = XW'(site_s2);
		in_range = (site_x < XW'(SITES));
		push_addr = '0;
		if (in_range) begin
			push_addr[0] = AW'(site_x);
			push_addr[1] = (col_s2 == '0) ? AW'(site_x + XW'(SIDE - 1))
				: AW'(site_x - XW'(1));
			push_addr[2] = (col_s2 == CW'(SIDE - 1)) ? AW'(site_x - XW'(SIDE - 1))
				: AW'(site_x + XW'(1));
			push_addr[3] = (site_x < XW'(SIDE)) ? AW'(site_x + XW'(SITES - SIDE))
				: AW'(site_x - XW'(SIDE));
			push_addr[4] = (site_x >= XW'(SITES - SIDE)) ? AW'(site_x - XW'(SITES - SIDE))
				: AW'(site_x + XW'(SIDE));
		end
		push                  = v_s2_q;
		push_ctl.force_wr     = (cmd_s2 == isms_pkg::CMD_FORCE);
		push_ctl.in_range     = in_range;
		push_ctl.write_spin   = wsp_s2;
		push_ctl.random_value = rnd_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
		end else begin
			v_s1_q <= accept;
			v_s2_q <= v_s1_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= cmd;
			site_s1 <= site_index;
			rnd_s1  <= random_value;
			wsp_s1  <= write_spin;
			row_s1  <= row_est;
		end
		if (v_s1_q) begin
			cmd_s2  <= cmd_s1;
			site_s2 <= site_s1;
			rnd_s2  <= rnd_s1;
			wsp_s2  <= wsp_s1;
			col_s2  <= CW'(col_fix);
		end
	end

endmodule

[hw/rtl/isms_back.sv]
`include "ising_metropolis_site_update_core_macros.svh"

module isms_back #(
	parameter int SIDE = 64,
	localparam int SITES = SIDE * SIDE,
	localparam int AW = $clog2(SITES)
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [isms_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [isms_pkg::CFG_W-1:0]            cfg_data,
	input  logic                                  q_valid,
	input  isms_pkg::item_ctl_t                   q_ctl,
	input  logic [isms_pkg::NBR_CNT-1:0][AW-1:0]  q_addr,
	output logic                                  pop,
	output logic                                  clearing,
	output logic                                  done,
	output logic                                  flipped,
	output logic signed [isms_pkg::ENERGY_W-1:0]  energy_total,
	output logic signed [isms_pkg::MAGNET_W-1:0]  magnetization_total,
	output logic signed [isms_pkg::DE_W-1:0]      energy_change
);

	localparam int EW = isms_pkg::ENERGY_W;
	localparam int MGW = isms_pkg::MAGNET_W;
	localparam int DW = isms_pkg::DE_W;
	localparam int CNTW = isms_pkg::NBR_IDX_W;
	localparam logic [EW-1:0] E_RST = EW'(-2 * SITES);
	localparam logic [MGW-1:0] M_RST = MGW'(SITES);

	isms_pkg::back_state_t state_q, state_d;

	logic [CNTW-1:0]                 rd_cnt_q;
	logic [isms_pkg::NBR_CNT-1:0]    nb_q;
	logic                            clr_active_q;
	logic [AW-1:0]                   clr_addr_q;
	logic [isms_pkg::CFG_W-1:0]      th4_q;
	logic [isms_pkg::CFG_W-1:0]      th8_q;
	logic signed [EW-1:0]            energy_q;
	logic signed [MGW-1:0]           magnet_q;
	logic                            done_q;
	logic                            flipped_q;
	logic signed [DW-1:0]            de_q;

	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic                  ram_wdata;
	logic [AW-1:0]         ram_raddr;
	logic                  ram_rdata;
	logic                  in_read;
	logic                  in_exec;
	logic [2:0]            n_up;
	logic signed [DW-1:0]  nsum2;
	logic signed [DW-1:0]  de;
	logic                  trial_ok;
	logic                  do_flip;

	isms_ram #(
		.WIDTH(1),
		.DEPTH(SITES)
	) u_lattice (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			isms_pkg::BK_IDLE: begin
				if (q_valid && !clr_active_q) begin
					state_d = isms_pkg::BK_READ;
				end
			end
			isms_pkg::BK_READ: begin
				if (rd_cnt_q == CNTW'(isms_pkg::NBR_CNT)) begin
					state_d = isms_pkg::BK_EXEC;
				end
			end
			isms_pkg::BK_EXEC: begin
				state_d = isms_pkg::BK_IDLE;
			end
			default: begin
				state_d = isms_pkg::BK_IDLE;
			end
		endcase
	end

	always_comb begin
		in_read = 1'b0;
		in_exec = 1'b0;
		unique case (state_q)
			isms_pkg::BK_READ: in_read = 1'b1;
			isms_pkg::BK_EXEC: in_exec = 1'b1;
			default: begin
				in_read = 1'b0;
				in_exec = 1'b0;
			end
		endcase
		pop = in_exec;
	end

	always_comb begin
		n_up  = 3'(nb_q[1]) + 3'(nb_q[2]) + 3'(nb_q[3]) + 3'(nb_q[4]);
		nsum2 = $signed({1'b0, n_up, 1'b0}) - 5'sd4;
		de    = nb_q[0] ? (nsum2 <<< 1) : -(nsum2 <<< 1);
		priority if (de[DW-1] || de == '0) begin
			trial_ok = 1'b1;
		end else if (de == 5'sd4) begin
			trial_ok = (q_ctl.random_value < th4_q);
		end else begin
			trial_ok = (q_ctl.random_value < th8_q);
		end
		do_flip = in_exec & q_ctl.in_range
			& (q_ctl.force_wr ? (nb_q[0] != q_ctl.write_spin) : trial_ok);
	end

	always_comb begin
		ram_raddr = (rd_cnt_q < CNTW'(isms_pkg::NBR_CNT)) ? q_addr[rd_cnt_q] : q_addr[0];
		ram_we    = clr_active_q | do_flip;
		ram_waddr = clr_active_q ? clr_addr_q : q_addr[0];
		ram_wdata = clr_active_q | ~nb_q[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= isms_pkg::BK_IDLE;
			rd_cnt_q     <= '0;
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
			th4_q        <= '0;
			th8_q        <= '0;
			energy_q     <= E_RST;
			magnet_q     <= M_RST;
			done_q       <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_cnt_q <= in_read ? rd_cnt_q + 1'b1 : '0;
			done_q   <= in_exec;
			if (clr_active_q) begin
				if (clr_addr_q == AW'(SITES - 1)) begin
					clr_active_q <= 1'b0;
				end else begin
					clr_addr_q <= clr_addr_q + 1'b1;
				end
			end
			if (cfg_we) begin
				unique case (isms_pkg::cfg_reg_t'(cfg_index))
					isms_pkg::CFG_THRESHOLD_DE4: th4_q <= cfg_data;
					isms_pkg::CFG_THRESHOLD_DE8: th8_q <= cfg_data;
				endcase
			end
			if (do_flip) begin
				energy_q <= energy_q + EW'(de);
				magnet_q <= nb_q[0] ? magnet_q - MGW'(2) : magnet_q + MGW'(2);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_read && rd_cnt_q != '0) begin
			nb_q <= {ram_rdata, nb_q[isms_pkg::NBR_CNT-1:1]};
		end
		if (in_exec) begin
			flipped_q <= do_flip;
			de_q      <= q_ctl.in_range ? de : '0;
		end
	end

	assign clearing            = clr_active_q;
	assign done                = done_q;
	assign flipped             = flipped_q;
	assign energy_total        = energy_q;
	assign magnetization_total = magnet_q;
	assign energy_change       = de_q;

	`ISMS_ASSERT_SAME(a_keep_energy, done_q && !flipped_q, $stable(energy_q), "energy moved without a flip")
	`ISMS_ASSERT_SAME(a_flip_magnet, done_q && flipped_q, magnet_q != $past(magnet_q), "flip left magnetization unchanged")
	`ISMS_ASSERT_SAME(a_de_legal, done_q, de_q == -5'sd8 || de_q == -5'sd4 || de_q == 5'sd0 || de_q == 5'sd4 || de_q == 5'sd8, "illegal energy change")
	`ISMS_ASSERT_NEXT(a_read_exec, state_q == isms_pkg::BK_READ && rd_cnt_q == CNTW'(isms_pkg::NBR_CNT), state_q == isms_pkg::BK_EXEC, "read phase did not end in execute")
	`ISMS_ASSERT_SAME(a_pop_nonempty, pop, q_valid && !clr_active_q, "pop from empty queue or during clear")

endmodule

[hw/rtl/ising_metropolis_site_update_core.sv]
// Metropolis single-spin-flip engine for a SIDE x SIDE periodic Ising lattice.
// Input: drive cmd, site_index, random_value, write_spin with start; a word is
// taken at a rising edge where start is high and busy is low. cmd trial runs a
// Metropolis test, cmd force writes write_spin into the site.
// Config: cfg_we with cfg_index/cfg_data writes the dE=4 or dE=8 threshold in
// the same edge; write only while the engine is idle.
// Output: one result word per input word, shown for one cycle with done high;
// the receiver cannot stall, so results must be taken when done is high.
// Flow: a word passes the front's s1 and s2 registers into a two-entry queue;
// the back end takes one word at a time: it picks the word up, issues and
// collects 5 serial reads through the lattice RAM's one read port for the
// site and its four neighbors, then updates the site. The front takes no
// new word while one is in s1 or s2 or while the queue is full.
// Reset: lattice returns to all +1, totals to the all-up values, thresholds to
// zero. After reset busy stays high while the lattice RAM is swept to +1.
module ising_metropolis_site_update_core #(
	parameter int SIDE = 64
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic                                  cmd,
	input  logic [isms_pkg::SITE_W-1:0]           site_index,
	input  logic [isms_pkg::RND_W-1:0]            random_value,
	input  logic                                  write_spin,
	input  logic                                  cfg_we,
	input  logic [isms_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [isms_pkg::CFG_W-1:0]            cfg_data,
	output logic                                  done,
	output logic                                  flipped,
	output logic signed [isms_pkg::ENERGY_W-1:0]  energy_total,
	output logic signed [isms_pkg::MAGNET_W-1:0]  magnetization_total,
	output logic signed [isms_pkg::DE_W-1:0]      energy_change
);

	localparam int SITES = SIDE * SIDE;
	localparam int AW = $clog2(SITES);
	localparam int QW = $bits(isms_pkg::item_ctl_t) + isms_pkg::NBR_CNT * AW;

	isms_pkg::front_hold_t                 hold;
	logic                                  push;
	isms_pkg::item_ctl_t                   push_ctl;
	logic [isms_pkg::NBR_CNT-1:0][AW-1:0]  push_addr;
	logic [QW-1:0]                         q_dout;
	logic                                  q_valid;
	logic                                  q_full;
	logic                                  pop;
	logic                                  clearing;
	isms_pkg::item_ctl_t                   q_ctl;
	logic [isms_pkg::NBR_CNT-1:0][AW-1:0]  q_addr;

	assign hold.q_full   = q_full;
	assign hold.clearing = clearing;
	assign {q_ctl, q_addr} = q_dout;

	isms_front #(
		.SIDE(SIDE)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.cmd         (cmd),
		.site_index  (site_index),
		.random_value(random_value),
		.write_spin  (write_spin),
		.hold        (hold),
		.busy        (busy),
		.push        (push),
		.push_ctl    (push_ctl),
		.push_addr   (push_addr)
	);

	isms_fifo #(
		.WIDTH(QW),
		.DEPTH(2)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   ({push_ctl, push_addr}),
		.pop   (pop),
		.dout  (q_dout),
		.valid (q_valid),
		.full  (q_full)
	);

	isms_back #(
		.SIDE(SIDE)
	) u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.q_valid            (q_valid),
		.q_ctl              (q_ctl),
		.q_addr             (q_addr),
		.pop                (pop),
		.clearing           (clearing),
		.done               (done),
		.flipped            (flipped),
		.energy_total       (energy_total),
		.magnetization_total(magnetization_total),
		.energy_change      (energy_change)
	);

endmodule
